### src/pvtf_pkg.sv
// ----------------------------------------------------------------------------
// pvtf_pkg: shared types and constants of the position/velocity tracker
// Command codes, register indexes, configuration bundle, reset values and
// the saturation helper used by both axes.
// ----------------------------------------------------------------------------
package pvtf_pkg;

  // Width of every position and velocity word (signed fixed point).
  localparam int POS_W      = 16;
  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 4;
  // Weight format: unsigned Q1.8, with 256 meaning "prediction only".
  localparam int WGT_W      = 9;
  localparam int FRAME_W    = 11;
  // Width of the configuration index and data.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DAT_W  = 16;
  // Width of the intermediate sums before saturation.
  localparam int SAT_IN_W   = 20;

  // Reset values of the registers.
  localparam logic [WGT_W-1:0]   WEIGHT_RST = 9'd77;
  localparam logic [WGT_W-1:0]   WEIGHT_MAX = 9'd256;
  localparam logic [POS_W-1:0]   HOME_X_RST = 16'd5120;
  localparam logic [POS_W-1:0]   HOME_Y_RST = 16'd3840;
  localparam logic [FRAME_W-1:0] FRAME_W_RST = 11'd640;
  localparam logic [FRAME_W-1:0] FRAME_H_RST = 11'd480;

  // Tracker commands.
  typedef enum logic [1:0] {
    CMD_PREDICT = 2'd0,
    CMD_UPDATE  = 2'd1,
    CMD_HOME    = 2'd2,
    CMD_LAST    = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT  = 3'd0,
    REG_HOME_X  = 3'd1,
    REG_HOME_Y  = 3'd2,
    REG_FRAME_W = 3'd3,
    REG_FRAME_H = 3'd4
  } reg_idx_t;

  // Configuration as seen by the datapath; the weight is already clamped.
  typedef struct packed {
    logic [WGT_W-1:0]          weight;
    logic signed [POS_W-1:0]   home_x;
    logic signed [POS_W-1:0]   home_y;
    logic [FRAME_W-1:0]        frame_w;
    logic [FRAME_W-1:0]        frame_h;
  } cfg_t;

  // Saturate a wide signed sum to a position word: in range when all the
  // bits above the sign bit of the result agree with it.
  function automatic logic signed [POS_W-1:0] sat_pos(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic in_range;
    in_range = (v[SAT_IN_W-1:POS_W-1] == '0) || (v[SAT_IN_W-1:POS_W-1] == '1);
    if (in_range) begin
      sat_pos = v[POS_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      sat_pos = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat_pos = {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

endpackage

### src/pvtf_cfg.sv
// ----------------------------------------------------------------------------
// pvtf_cfg: configuration register bank
// Holds the blend weight, home position and frame size, written one word at
// a time over the configuration channel. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module pvtf_cfg
  import pvtf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  logic [WGT_W-1:0]        weight;
  logic signed [POS_W-1:0] home_x;
  logic signed [POS_W-1:0] home_y;
  logic [FRAME_W-1:0]      frame_w;
  logic [FRAME_W-1:0]      frame_h;

  // The bank takes a word in every cycle.
  assign cfg_ready = 1'b1;

  // Register writes, each keeping the low bits of the data word.
  always_ff @(posedge clk) begin
    if (rst) begin
      weight  <= WEIGHT_RST;
      home_x  <= HOME_X_RST;
      home_y  <= HOME_Y_RST;
      frame_w <= FRAME_W_RST;
      frame_h <= FRAME_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_WEIGHT:  weight  <= cfg_data[WGT_W-1:0];
        REG_HOME_X:  home_x  <= cfg_data[POS_W-1:0];
        REG_HOME_Y:  home_y  <= cfg_data[POS_W-1:0];
        REG_FRAME_W: frame_w <= cfg_data[FRAME_W-1:0];
        REG_FRAME_H: frame_h <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // A weight above one is treated as one: prediction only.
  always_comb begin
    cfg.weight  = (weight > WEIGHT_MAX) ? WEIGHT_MAX : weight;
    cfg.home_x  = home_x;
    cfg.home_y  = home_y;
    cfg.frame_w = frame_w;
    cfg.frame_h = frame_h;
  end

endmodule

### src/pvtf_axis.sv
// ----------------------------------------------------------------------------
// pvtf_axis: next-state logic of one axis
// Works out the new prediction, velocity and previous position of one axis
// for a command, and whether the new position lies outside the frame.
// ----------------------------------------------------------------------------
module pvtf_axis
  import pvtf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  cmd_t                     cmd,
  input  logic signed [POS_W-1:0]  pred,
  input  logic signed [POS_W-1:0]  vel,
  input  logic signed [POS_W-1:0]  prev,
  input  logic signed [POS_W-1:0]  meas,
  input  logic signed [POS_W-1:0]  home,
  input  logic [WGT_W-1:0]         weight,
  input  logic [FRAME_W-1:0]       frame_lim,
  output logic signed [POS_W-1:0]  pred_next,
  output logic signed [POS_W-1:0]  vel_next,
  output logic signed [POS_W-1:0]  prev_next,
  output logic                     oof
);

  localparam int DIFF_W = POS_W + 1;
  localparam int PROD_W = WGT_W + 1 + DIFF_W;
  localparam int LIM_W  = FRAME_W + FRAC_BITS;
  localparam int CMP_W  = ((LIM_W > POS_W) ? LIM_W : POS_W) + 1;

  logic signed [POS_W-1:0]    vel_q;
  logic signed [SAT_IN_W-1:0] step_sum;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAT_IN_W-1:0] blend_sum;
  logic signed [POS_W-1:0]    blend_pos;
  logic signed [SAT_IN_W-1:0] vel_diff;
  logic signed [CMP_W-1:0]    pos_cmp;
  logic signed [CMP_W-1:0]    lim_cmp;

  // Predict: advance by 1.25 times the velocity.
  always_comb begin
    vel_q    = vel >>> 2;
    step_sum = SAT_IN_W'(pred) + SAT_IN_W'(vel) + SAT_IN_W'(vel_q);
  end

  // Update: meas + w*(pred - meas)/256 equals the weighted blend, floor
  // shift included, with a single multiply.
  always_comb begin
    diff      = DIFF_W'(pred) - DIFF_W'(meas);
    prod      = $signed({{(PROD_W-WGT_W){1'b0}}, weight}) * PROD_W'(diff);
    blend_sum = SAT_IN_W'(meas) + SAT_IN_W'($signed(prod[PROD_W-1:8]));
    blend_pos = sat_pos(blend_sum);
    vel_diff  = SAT_IN_W'(blend_pos) - SAT_IN_W'(pred);
  end

  // Command select.
  always_comb begin
    case (cmd)
      CMD_PREDICT: begin
        pred_next = sat_pos(step_sum);
        vel_next  = vel;
        prev_next = pred;
      end
      CMD_UPDATE: begin
        pred_next = blend_pos;
        vel_next  = sat_pos(vel_diff);
        prev_next = pred;
      end
      CMD_HOME: begin
        pred_next = home;
        vel_next  = '0;
        prev_next = prev;
      end
      default: begin
        pred_next = prev;
        vel_next  = '0;
        prev_next = prev;
      end
    endcase
  end

  // Frame check: below zero or beyond the scaled frame limit.
  always_comb begin
    pos_cmp = CMP_W'(pred_next);
    lim_cmp = $signed({{(CMP_W-LIM_W){1'b0}}, frame_lim, {FRAC_BITS{1'b0}}});
    oof     = pred_next[POS_W-1] || (pos_cmp > lim_cmp);
  end

endmodule

### src/position_velocity_tracking_filter.sv
// ----------------------------------------------------------------------------
// position_velocity_tracking_filter: 2D alpha-beta style object tracker
// Keeps a predicted position, velocity and previous position in signed
// fixed point and answers each command word with the new pose, velocity
// and an out-of-frame flag.
//
//   channel  dir  width  contents
//   s_axis   in   32+2   tdata: meas_x, meas_y   tuser: cmd
//   m_axis   out  64+1   tdata: pose_x, pose_y, vel_x, vel_y
//                        tuser: out_of_frame
//   cfg      in   3+16   register index, write data
//
// One word per cycle in and out unless the result stalls; a word passes
// the input register, then the result register. The tracker state updates
// in the same cycle as the result register, so the next word sees it at once.
// Reset clears the handshake flags, restores the register defaults and
// puts the tracker at the home position with zero velocity.
// A stalled result holds the input register; s_axis_tready drops only
// when both stages hold a word.
// ----------------------------------------------------------------------------
module position_velocity_tracking_filter
  import pvtf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input words.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // [15:0] meas_x, [31:16] meas_y
  input  logic [1:0]           s_axis_tuser,   // [1:0] cmd
  // Result words.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // pose_x, pose_y, vel_x, vel_y
  output logic                 m_axis_tuser,   // [0] out_of_frame
  // Configuration writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t cfg;

  // Input register.
  logic                    in_full;
  cmd_t                    in_cmd;
  logic signed [POS_W-1:0] in_mx;
  logic signed [POS_W-1:0] in_my;

  // Tracker state.
  logic signed [POS_W-1:0] pred_x, pred_y, vel_x, vel_y, prev_x, prev_y;
  logic signed [POS_W-1:0] pred_x_next, pred_y_next, vel_x_next, vel_y_next;
  logic signed [POS_W-1:0] prev_x_next, prev_y_next;
  logic                    oof_x, oof_y;

  logic adv;

  pvtf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A held word moves on when the result register is free or being read.
  assign adv           = in_full && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_full || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tready) begin
      in_full <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd <= cmd_t'(s_axis_tuser);
      in_mx  <= s_axis_tdata[15:0];
      in_my  <= s_axis_tdata[31:16];
    end
  end

  pvtf_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .cmd       (in_cmd),
    .pred      (pred_x),
    .vel       (vel_x),
    .prev      (prev_x),
    .meas      (in_mx),
    .home      (cfg.home_x),
    .weight    (cfg.weight),
    .frame_lim (cfg.frame_w),
    .pred_next (pred_x_next),
    .vel_next  (vel_x_next),
    .prev_next (prev_x_next),
    .oof       (oof_x)
  );

  pvtf_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .cmd       (in_cmd),
    .pred      (pred_y),
    .vel       (vel_y),
    .prev      (prev_y),
    .meas      (in_my),
    .home      (cfg.home_y),
    .weight    (cfg.weight),
    .frame_lim (cfg.frame_h),
    .pred_next (pred_y_next),
    .vel_next  (vel_y_next),
    .prev_next (prev_y_next),
    .oof       (oof_y)
  );

  // Tracker state advances with each word that moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      pred_x <= HOME_X_RST;
      pred_y <= HOME_Y_RST;
      vel_x  <= '0;
      vel_y  <= '0;
      prev_x <= '0;
      prev_y <= '0;
    end else if (adv) begin
      pred_x <= pred_x_next;
      pred_y <= pred_y_next;
      vel_x  <= vel_x_next;
      vel_y  <= vel_y_next;
      prev_x <= prev_x_next;
      prev_y <= prev_y_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {vel_y_next, vel_x_next, pred_y_next, pred_x_next};
      m_axis_tuser <= oof_x || oof_y;
    end
  end

  // A word that moves on always leaves a result behind it.
  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_axis_tvalid)
    else $error("result register not loaded after a word moved on");

  // A held word is never dropped while the result stalls.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_full && !adv |=> in_full)
    else $error("input word lost while stalled");

  // Both reset commands clear the velocity.
  a_reset_vel: assert property (@(posedge clk) disable iff (rst)
    adv && (in_cmd == CMD_HOME || in_cmd == CMD_LAST) |=> vel_x == '0 && vel_y == '0)
    else $error("velocity not cleared by a reset command");

  // Predict leaves the velocity untouched.
  a_predict_vel: assert property (@(posedge clk) disable iff (rst)
    adv && in_cmd == CMD_PREDICT |=> $stable(vel_x) && $stable(vel_y))
    else $error("velocity changed by predict");

  // A negative pose in the result is always flagged out of frame.
  a_neg_oof: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[15] || m_axis_tdata[31]) |-> m_axis_tuser)
    else $error("negative pose not flagged out of frame");

endmodule
